@@ rtl/grid_rectangle_count_query_top_defines.svh @@
// ----------------------------------------------------------------------------
// grid rectangle count query assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef GRID_RECTANGLE_COUNT_QUERY_TOP_DEFINES_SVH
`define GRID_RECTANGLE_COUNT_QUERY_TOP_DEFINES_SVH

// same-cycle implication
`define GRCQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grcq assertion failed");

// next-cycle implication
`define GRCQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grcq assertion failed");

`endif

@@ rtl/grcq_pkg.sv @@
// ----------------------------------------------------------------------------
// grcq_pkg
// shared constants, codes and types of the grid rectangle count query block
// ----------------------------------------------------------------------------
`default_nettype none

package grcq_pkg;

  localparam int GRID_MAX  = 256;
  localparam int COORD_W   = 9;
  localparam int IDX_W     = $clog2(GRID_MAX);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int PREFIX_W  = $clog2(GRID_MAX + 1);
  localparam int COUNT_W   = 17;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic clear;
    logic add;
    logic lo_zero;
  } acc_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/grcq_prefix_mem.sv @@
// ----------------------------------------------------------------------------
// grcq_prefix_mem
// row prefix count store, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module grcq_prefix_mem (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [grcq_pkg::ADDR_W-1:0]            wr_addr_i,
  input  logic [grcq_pkg::PREFIX_W-1:0]          wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [grcq_pkg::ADDR_W-1:0]            rd_hi_addr_i,
  input  logic [grcq_pkg::ADDR_W-1:0]            rd_lo_addr_i,
  output logic [grcq_pkg::PREFIX_W-1:0]          rd_hi_data_o,
  output logic [grcq_pkg::PREFIX_W-1:0]          rd_lo_data_o
);
  import grcq_pkg::*;

  logic [PREFIX_W-1:0] mem_q [GRID_MAX*GRID_MAX];
  logic [PREFIX_W-1:0] hi_q;
  logic [PREFIX_W-1:0] lo_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      hi_q <= mem_q[rd_hi_addr_i];
      lo_q <= mem_q[rd_lo_addr_i];
    end
  end

  assign rd_hi_data_o = hi_q;
  assign rd_lo_data_o = lo_q;

endmodule

`default_nettype wire

@@ rtl/grcq_accum.sv @@
// ----------------------------------------------------------------------------
// grcq_accum
// shared compare, subtract and saturating add unit for the row walk
// ----------------------------------------------------------------------------
`default_nettype none

module grcq_accum (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  grcq_pkg::acc_ctrl_t                    ctrl_i,
  input  logic [grcq_pkg::PREFIX_W-1:0]          hi_i,
  input  logic [grcq_pkg::PREFIX_W-1:0]          lo_i,
  output logic [grcq_pkg::COUNT_W-1:0]           total_o
);
  import grcq_pkg::*;

  logic [COUNT_W-1:0]  total_q, total_d;
  logic [PREFIX_W-1:0] lo_eff;
  logic [PREFIX_W-1:0] diff;
  logic [COUNT_W:0]    sum;

  always_comb begin
    lo_eff  = ctrl_i.lo_zero ? '0 : lo_i;
    diff    = (hi_i > lo_eff) ? PREFIX_W'(hi_i - lo_eff) : '0;
    sum     = {1'b0, total_q} + (COUNT_W+1)'(diff);
    total_d = total_q;
    if (ctrl_i.clear) begin
      total_d = '0;
    end else if (ctrl_i.add) begin
      total_d = (sum > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  assign total_o = total_q;

endmodule

`default_nettype wire

@@ rtl/grcq_seq.sv @@
// ----------------------------------------------------------------------------
// grcq_seq
// command sequencer: load pointer, query check, row walk and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "grid_rectangle_count_query_top_defines.svh"

module grcq_seq (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             cmd_i,
  input  logic                                   cell_marked_i,
  input  logic [grcq_pkg::COORD_W-1:0]           row_first_i,
  input  logic [grcq_pkg::COORD_W-1:0]           col_first_i,
  input  logic [grcq_pkg::COORD_W-1:0]           row_last_i,
  input  logic [grcq_pkg::COORD_W-1:0]           col_last_i,
  input  logic                                   cfg_we_i,
  input  logic [grcq_pkg::COORD_W-1:0]           cfg_wdata_i,
  output logic                                   wr_en_o,
  output logic [grcq_pkg::ADDR_W-1:0]            wr_addr_o,
  output logic [grcq_pkg::PREFIX_W-1:0]          wr_data_o,
  output logic                                   rd_en_o,
  output logic [grcq_pkg::ADDR_W-1:0]            rd_hi_addr_o,
  output logic [grcq_pkg::ADDR_W-1:0]            rd_lo_addr_o,
  output grcq_pkg::acc_ctrl_t                    acc_ctrl_o,
  input  logic [grcq_pkg::COUNT_W-1:0]           total_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [grcq_pkg::COUNT_W-1:0]           out_count_o,
  output logic                                   out_bad_o
);
  import grcq_pkg::*;

  state_e               state_q, state_d;
  logic [COORD_W-1:0]   grid_size_q;
  logic [COORD_W-1:0]   load_row_q, load_row_d;
  logic [COORD_W-1:0]   load_col_q, load_col_d;
  logic [PREFIX_W-1:0]  run_sum_q, run_sum_d;
  logic [COORD_W-1:0]   row_q, row_d;
  logic [COORD_W-1:0]   row_last_q, row_last_d;
  logic [COORD_W-1:0]   col_first_q, col_first_d;
  logic [COORD_W-1:0]   col_last_q, col_last_d;
  logic                 res_bad_q, res_bad_d;
  logic                 add_q;
  logic                 lo_zero_q;
  logic                 out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]   out_count_q, out_count_d;
  logic                 out_bad_q, out_bad_d;

  logic [COORD_W-1:0]   n_use;
  logic                 accept;
  logic [COORD_W-1:0]   eff_row;
  logic [COORD_W-1:0]   eff_col;
  logic [PREFIX_W-1:0]  eff_sum;
  logic [PREFIX_W-1:0]  new_sum;
  logic [COORD_W-1:0]   next_col;
  logic                 do_wr;
  logic                 query_bad;
  logic                 acc_clear;

  assign n_use  = (grid_size_q > COORD_W'(GRID_MAX)) ? COORD_W'(GRID_MAX) : grid_size_q;
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // load position, with wrap to the next row when the size shrank
  always_comb begin
    eff_row = load_row_q;
    eff_col = load_col_q;
    eff_sum = run_sum_q;
    do_wr   = 1'b0;
    if (load_row_q <= n_use) begin
      if (load_col_q > n_use) begin
        eff_col = COORD_W'(1);
        eff_row = COORD_W'(load_row_q + COORD_W'(1));
        eff_sum = '0;
      end
      do_wr = (eff_row <= n_use);
    end
    new_sum  = PREFIX_W'(eff_sum + PREFIX_W'(cell_marked_i));
    next_col = COORD_W'(eff_col + COORD_W'(1));
  end

  assign query_bad = (row_first_i == '0) || (col_first_i == '0) ||
                     (row_first_i > row_last_i) || (col_first_i > col_last_i) ||
                     (row_last_i > n_use) || (col_last_i > n_use);

  assign wr_en_o   = accept && (cmd_e'(cmd_i) == CMD_LOAD) && do_wr;
  assign wr_addr_o = {IDX_W'(eff_row - COORD_W'(1)), IDX_W'(eff_col - COORD_W'(1))};
  assign wr_data_o = new_sum;

  always_comb begin
    state_d      = state_q;
    load_row_d   = load_row_q;
    load_col_d   = load_col_q;
    run_sum_d    = run_sum_q;
    row_d        = row_q;
    row_last_d   = row_last_q;
    col_first_d  = col_first_q;
    col_last_d   = col_last_q;
    res_bad_d    = res_bad_q;
    acc_clear    = 1'b0;
    rd_en_o      = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_count_d  = out_count_q;
    out_bad_d    = out_bad_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_LOAD: begin
              if (load_row_q <= n_use) begin
                if (!do_wr) begin
                  load_row_d = eff_row;
                  load_col_d = COORD_W'(1);
                  run_sum_d  = '0;
                end else if (next_col > n_use) begin
                  load_row_d = COORD_W'(eff_row + COORD_W'(1));
                  load_col_d = COORD_W'(1);
                  run_sum_d  = '0;
                end else begin
                  load_row_d = eff_row;
                  load_col_d = next_col;
                  run_sum_d  = new_sum;
                end
              end
            end
            CMD_RESTART: begin
              load_row_d = COORD_W'(1);
              load_col_d = COORD_W'(1);
              run_sum_d  = '0;
            end
            CMD_QUERY: begin
              acc_clear   = 1'b1;
              res_bad_d   = query_bad;
              row_d       = row_first_i;
              row_last_d  = row_last_i;
              col_first_d = col_first_i;
              col_last_d  = col_last_i;
              state_d     = query_bad ? ST_FINISH : ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        rd_en_o = 1'b1;
        if (row_q == row_last_q) begin
          state_d = ST_DRAIN;
        end else begin
          row_d = COORD_W'(row_q + COORD_W'(1));
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_count_d = res_bad_q ? '0 : total_i;
          out_bad_d   = res_bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_hi_addr_o = {IDX_W'(row_q - COORD_W'(1)), IDX_W'(col_last_q - COORD_W'(1))};
  assign rd_lo_addr_o = {IDX_W'(row_q - COORD_W'(1)), IDX_W'(col_first_q - COORD_W'(2))};

  assign acc_ctrl_o.clear   = acc_clear;
  assign acc_ctrl_o.add     = add_q;
  assign acc_ctrl_o.lo_zero = lo_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grid_size_q <= COORD_W'(GRID_MAX);
      load_row_q  <= COORD_W'(1);
      load_col_q  <= COORD_W'(1);
      run_sum_q   <= '0;
      add_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_row_q  <= load_row_d;
      load_col_q  <= load_col_d;
      run_sum_q   <= run_sum_d;
      add_q       <= rd_en_o;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        grid_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    row_last_q  <= row_last_d;
    col_first_q <= col_first_d;
    col_last_q  <= col_last_d;
    res_bad_q   <= res_bad_d;
    lo_zero_q   <= (col_first_q == COORD_W'(1));
    out_count_q <= out_count_d;
    out_bad_q   <= out_bad_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;
  assign out_bad_o   = out_bad_q;

  `GRCQ_ASSERT_IMP(a_sum_within_col, 1'b1, run_sum_q <= PREFIX_W'(load_col_q - COORD_W'(1)))
  `GRCQ_ASSERT_IMP(a_add_in_walk, add_q, (state_q == ST_RUN) || (state_q == ST_DRAIN))
  `GRCQ_ASSERT_IMP(a_row_in_range, state_q == ST_RUN, row_q <= row_last_q)
  `GRCQ_ASSERT_NXT(a_finish_posts, (state_q == ST_FINISH) && (!out_valid_q || out_ready_i),
                   out_valid_q && (state_q == ST_IDLE))

endmodule

`default_nettype wire

@@ rtl/grid_rectangle_count_query_top.sv @@
// ----------------------------------------------------------------------------
// grid_rectangle_count_query_top
// load and restart items are taken in idle; the block is ready again next cycle
// a query walks its rows in ST_RUN, one prefix pair per row from the two-port
// prefix store, then passes ST_DRAIN and ST_FINISH to the result register; a
// rejected query goes straight to ST_FINISH; no new item during the walk
// reset clears control state; the prefix store holds garbage until loaded
// ----------------------------------------------------------------------------
`default_nettype none

module grid_rectangle_count_query_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_marked, row_first, col_first, row_last, col_last, zero pad
  input  logic [39:0] s_axis_tdata,
  // command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // marked_count, zero pad
  output logic [23:0] m_axis_tdata,
  // bad_query
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);
  import grcq_pkg::*;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [PREFIX_W-1:0] wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_hi_addr;
  logic [ADDR_W-1:0]   rd_lo_addr;
  logic [PREFIX_W-1:0] rd_hi_data;
  logic [PREFIX_W-1:0] rd_lo_data;
  acc_ctrl_t           acc_ctrl;
  logic [COUNT_W-1:0]  total;
  logic [COUNT_W-1:0]  out_count;
  logic                out_bad;

  grcq_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .cmd_i         (s_axis_tuser),
    .cell_marked_i (s_axis_tdata[0]),
    .row_first_i   (s_axis_tdata[9:1]),
    .col_first_i   (s_axis_tdata[18:10]),
    .row_last_i    (s_axis_tdata[27:19]),
    .col_last_i    (s_axis_tdata[36:28]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_en_o       (rd_en),
    .rd_hi_addr_o  (rd_hi_addr),
    .rd_lo_addr_o  (rd_lo_addr),
    .acc_ctrl_o    (acc_ctrl),
    .total_i       (total),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_count_o   (out_count),
    .out_bad_o     (out_bad)
  );

  grcq_prefix_mem u_mem (
    .clk_i        (clk_i),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_data_i    (wr_data),
    .rd_en_i      (rd_en),
    .rd_hi_addr_i (rd_hi_addr),
    .rd_lo_addr_i (rd_lo_addr),
    .rd_hi_data_o (rd_hi_data),
    .rd_lo_data_o (rd_lo_data)
  );

  grcq_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .hi_i    (rd_hi_data),
    .lo_i    (rd_lo_data),
    .total_o (total)
  );

  assign m_axis_tdata = {7'b0, out_count};
  assign m_axis_tuser = out_bad;

endmodule

`default_nettype wire

@@ tb/grcq_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grcq_tb_pkg
// item types and scoreboard for the grid rectangle count query testbench;
// the scoreboard tracks the load position, row prefix store and grid size,
// works out each query count as the query is accepted and checks results
// in order against those counts
// ----------------------------------------------------------------------------
package grcq_tb_pkg;
  import grcq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STORE_DEPTH = GRID_MAX * GRID_MAX;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [1:0]         cmd;
    logic               marked;
    logic [COORD_W-1:0] row_first;
    logic [COORD_W-1:0] col_first;
    logic [COORD_W-1:0] row_last;
    logic [COORD_W-1:0] col_last;
  } grid_item_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               bad;
  } count_result_t;

  class rect_count_scoreboard;
    logic [COORD_W-1:0] grid_size;
    logic [8:0]         prefix_store [STORE_DEPTH];
    bit                 written [STORE_DEPTH];
    int unsigned        load_row;
    int unsigned        load_col;
    int unsigned        row_sum;
    count_result_t      pending_counts [$];
    int unsigned        mismatches;

    function new();
      grid_size = 9'd256;
      load_row = 1;
      load_col = 1;
      row_sum = 0;
      mismatches = 0;
      foreach (written[i]) begin
        written[i] = 1'b0;
        prefix_store[i] = '0;
      end
    endfunction

    function int unsigned side();
      return (grid_size > GRID_MAX) ? GRID_MAX : grid_size;
    endfunction

    function int unsigned cell_index(int unsigned row, int unsigned col);
      return (row - 1) * GRID_MAX + (col - 1);
    endfunction

    function int unsigned prefix_at(int unsigned row, int unsigned col);
      if (col == 0) return 0;
      return prefix_store[cell_index(row, col)];
    endfunction

    function bit is_rejected(grid_item_t it, int unsigned n);
      return it.row_first < 1 || it.col_first < 1 || it.row_first > it.row_last ||
             it.col_first > it.col_last || it.row_last > n || it.col_last > n;
    endfunction

    // a load still lands somewhere in the grid
    function bit load_has_effect();
      int unsigned n;
      n = side();
      if (load_row > n) return 1'b0;
      if (load_col > n && load_row + 1 > n) return 1'b0;
      return 1'b1;
    endfunction

    function bit reads_unwritten(grid_item_t it);
      int unsigned n;
      n = side();
      if (is_rejected(it, n)) return 1'b0;
      for (int unsigned r = it.row_first; r <= it.row_last; r++) begin
        if (!written[cell_index(r, it.col_last)]) return 1'b1;
        if (it.col_first > 1 && !written[cell_index(r, it.col_first - 1)]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void load_cell(logic mark);
      int unsigned n;
      int unsigned idx;
      n = side();
      if (load_row > n) return;
      // size shrunk under the load position
      if (load_col > n) begin
        load_col = 1;
        load_row++;
        row_sum = 0;
        if (load_row > n) return;
      end
      row_sum += mark;
      idx = cell_index(load_row, load_col);
      prefix_store[idx] = 9'(row_sum);
      written[idx] = 1'b1;
      load_col++;
      if (load_col > n) begin
        load_col = 1;
        load_row++;
        row_sum = 0;
      end
    endfunction

    function count_result_t predict_count(grid_item_t it);
      count_result_t res;
      int unsigned   n;
      int unsigned   hi;
      int unsigned   lo;
      int unsigned   total;
      n = side();
      res.count = '0;
      res.bad = 1'b0;
      total = 0;
      if (is_rejected(it, n)) begin
        res.bad = 1'b1;
        return res;
      end
      for (int unsigned r = it.row_first; r <= it.row_last; r++) begin
        hi = prefix_at(r, it.col_last);
        lo = prefix_at(r, it.col_first - 1);
        // stale entries can leave the right prefix below the left one
        if (hi > lo) total += hi - lo;
        if (total > COUNT_MAX) total = COUNT_MAX;
      end
      res.count = COUNT_W'(total);
      return res;
    endfunction

    function void note_input(grid_item_t it);
      case (it.cmd)
        CMD_LOAD: load_cell(it.marked);
        CMD_RESTART: begin
          load_row = 1;
          load_col = 1;
          row_sum = 0;
        end
        CMD_QUERY: pending_counts.insert(pending_counts.size(), predict_count(it));
        default: ;
      endcase
    endfunction

    function void check_result(logic [COUNT_W-1:0] count, logic bad);
      count_result_t want;
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch %0d: result with no query waiting, got count %0d bad %0d",
                   mismatches, count, bad);
        return;
      end
      want = pending_counts[0];
      pending_counts.delete(0);
      if (want.count !== count || want.bad !== bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch %0d: expected count %0d bad %0d, got count %0d bad %0d",
                   mismatches, want.count, want.bad, count, bad);
      end
    endfunction
  endclass

endpackage

@@ tb/tb_grid_rectangle_count_query_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_rectangle_count_query_top
// drives loads, restarts and rectangle queries into the block over a range of
// grid sizes, with directed corner cases first and random traffic after;
// both stream sides idle at random and the result side holds off once for a
// long stretch; every result is checked against the scoreboard count
// ----------------------------------------------------------------------------
module tb_grid_rectangle_count_query_top;
  import grcq_pkg::*;
  import grcq_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 270;
  localparam int PHASE_ITEMS = 18;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [8:0]  cfg_wdata_i;

  rect_count_scoreboard sb;
  bit          idle_on = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned cycle_count = 0;

  grid_rectangle_count_query_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata[COUNT_W-1:0], m_axis_tuser[0]);
        stall_left = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_request) begin
        stall_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic grid_item_t noise_item();
    grid_item_t it;
    it.cmd = 2'($urandom_range(0, 3));
    it.marked = 1'($urandom_range(0, 1));
    it.row_first = 9'($urandom_range(0, 511));
    it.col_first = 9'($urandom_range(0, 511));
    it.row_last = 9'($urandom_range(0, 511));
    it.col_last = 9'($urandom_range(0, 511));
    return it;
  endfunction

  function automatic grid_item_t make_query(bit want_valid);
    grid_item_t  q;
    int unsigned n;
    int unsigned lim;
    int unsigned a;
    int unsigned b;
    q = noise_item();
    q.cmd = CMD_QUERY;
    n = sb.side();
    if (want_valid && n > 0) begin
      for (int tries = 0; tries < 16; tries++) begin
        lim = ($urandom_range(0, 1) == 0 && n > 4) ? 4 : n;
        a = $urandom_range(1, lim);
        b = $urandom_range(1, lim);
        q.row_first = 9'((a < b) ? a : b);
        q.row_last = 9'((a < b) ? b : a);
        a = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, n);
        b = ($urandom_range(0, 3) == 0) ? n : $urandom_range(1, n);
        q.col_first = 9'((a < b) ? a : b);
        q.col_last = 9'((a < b) ? b : a);
        if (!sb.reads_unwritten(q)) return q;
      end
    end
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: q.row_first = '0;
          1: q.col_first = '0;
          2: q.row_last = '0;
          default: q.col_last = '0;
        endcase
      end
      1: begin
        a = $urandom_range(2, 511);
        q.row_first = 9'(a);
        q.row_last = 9'($urandom_range(1, a - 1));
      end
      2: begin
        a = $urandom_range(2, 511);
        q.col_first = 9'(a);
        q.col_last = 9'($urandom_range(1, a - 1));
      end
      default: begin
        a = $urandom_range(n + 1, 511);
        if ($urandom_range(0, 1) == 0) q.row_last = 9'(a);
        else q.col_last = 9'(a);
      end
    endcase
    return q;
  endfunction

  task automatic send_item(grid_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.cmd;
    s_axis_tdata <= {3'b000, it.col_last, it.row_last, it.col_first, it.row_first, it.marked};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(it);
  endtask

  task automatic send_cmd(logic [1:0] cmd);
    grid_item_t it;
    it = noise_item();
    it.cmd = cmd;
    send_item(it);
  endtask

  task automatic send_load(logic mark);
    grid_item_t it;
    it = noise_item();
    it.cmd = CMD_LOAD;
    it.marked = mark;
    send_item(it);
  endtask

  task automatic load_run(int unsigned count, int unsigned density);
    repeat (count) send_load($urandom_range(0, 99) < density);
  endtask

  task automatic send_query(input int unsigned r1, input int unsigned c1,
                            input int unsigned r2, input int unsigned c2);
    grid_item_t it;
    it = noise_item();
    it.cmd = CMD_QUERY;
    it.row_first = 9'(r1);
    it.col_first = 9'(c1);
    it.row_last = 9'(r2);
    it.col_last = 9'(c2);
    send_item(it);
  endtask

  // register write only once the block has gone quiet
  task automatic write_grid_size(logic [8:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_counts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.grid_size = value;
  endtask

  task automatic fill_grid(int unsigned rows);
    int unsigned density;
    case ($urandom_range(0, 3))
      0: density = 0;
      1: density = 100;
      2: density = 50;
      default: density = $urandom_range(0, 100);
    endcase
    send_cmd(CMD_RESTART);
    load_run(rows * sb.side(), density);
  endtask

  task automatic random_phase(logic [8:0] size, int unsigned goal);
    int unsigned done;
    int unsigned pick;
    int unsigned n;
    int unsigned rows;
    write_grid_size(size);
    n = sb.side();
    rows = (n <= 16) ? n : 1;
    fill_grid(rows);
    done = 0;
    while (done < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_item(make_query(pick < 50));
        done++;
      end else if (pick < 72) begin
        if (sb.load_has_effect()) done++;
        send_load(1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
        send_cmd(CMD_RESTART);
        load_run($urandom_range(0, (n * n < 64) ? n * n : 64), $urandom_range(0, 100));
        done++;
      end else if (pick < 84) begin
        fill_grid(rows);
        done++;
      end else if (pick < 92) begin
        send_cmd(CMD_UNUSED);
      end else begin
        send_cmd(CMD_RESTART);
        done++;
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full size grid at reset value, first two rows loaded
    load_run(256, 100);
    load_run(256, 50);
    // result side holds off while the queries keep coming
    hold_request = 1'b1;
    send_query(1, 1, 1, 256);
    send_query(1, 256, 2, 256);
    send_query(2, 1, 2, 1);
    send_query(1, 1, 2, 256);
    send_query(2, 128, 1, 200);
    send_query(1, 9, 2, 8);
    send_query(0, 1, 1, 1);
    send_query(1, 0, 1, 1);
    send_query(1, 1, 257, 1);
    send_query(1, 1, 1, 511);
    send_query(511, 511, 511, 511);
    send_cmd(CMD_UNUSED);

    // one cell grid, load past the end is dropped
    write_grid_size(9'd1);
    send_cmd(CMD_RESTART);
    send_load(1'b1);
    send_load(1'b0);
    send_query(1, 1, 1, 1);
    send_query(1, 1, 1, 2);
    send_query(2, 1, 2, 1);

    // zero size grid
    write_grid_size(9'd0);
    send_load(1'b1);
    send_query(1, 1, 1, 1);

    // stale prefixes above the new ones
    write_grid_size(9'd4);
    send_cmd(CMD_RESTART);
    load_run(16, 0);
    send_cmd(CMD_RESTART);
    load_run(2, 100);
    send_query(1, 3, 1, 3);
    send_query(1, 1, 4, 4);

    // shrink while the load position is past the new size
    write_grid_size(9'd8);
    send_cmd(CMD_RESTART);
    load_run(6, 50);
    write_grid_size(9'd4);
    load_run(12, 50);
    send_query(1, 1, 4, 4);
    send_query(2, 2, 4, 3);

    // oversize register value acts as the largest grid
    write_grid_size(9'd511);
    send_query(1, 1, 2, 256);
    send_query(1, 1, 1, 257);

    random_phase(9'd3, PHASE_ITEMS);
    random_phase(9'd2, PHASE_ITEMS);
    idle_on = 1'b0;
    random_phase(9'd4, PHASE_ITEMS);
    idle_on = 1'b1;
    random_phase(9'd1, PHASE_ITEMS);

    s_axis_tvalid <= 1'b0;
    while (sb.pending_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_counts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
